@@ sv/lpfd_pkg.sv @@
package lpfd_pkg;

   // register map, selected by csr_paddr[2]
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_MARKER = 1'b0;
   localparam logic CSR_IDX_MAX_LEN = 1'b1;

   // register reset values
   localparam logic [7:0] MARKER_RESET = 8'h3E;
   localparam logic [15:0] MAX_LEN_RESET = 16'd256;

   // queue between the header parser and the result port
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // parser phase
   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LOW  = 2'd1,
      PH_HIGH = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   // one payload word on its way out
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        first_of_frame;
      logic        last_of_frame;
      logic [15:0] frame_length;
   } word_type;

endpackage

@@ sv/lpfd_front.sv @@
module lpfd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        rx_byte,
   input  logic [7:0]        marker,
   input  logic [15:0]       max_len,
   input  logic              queue_full,
   output logic              push_valid,
   output lpfd_pkg::word_type push_word
);
   import lpfd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  len_low_ff, len_low_in;
   logic [15:0] hdr_len_ff, hdr_len_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] rx_len;
   logic        accept;
   logic        last_byte;

   // take a word whenever the queue has room
   assign in_ready = !queue_full;
   assign accept = in_valid && in_ready;
   assign rx_len = {rx_byte, len_low_ff};
   assign last_byte = (remain_ff <= 16'd1);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         len_low_ff <= '0;
         hdr_len_ff <= '0;
         remain_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         len_low_ff <= len_low_in;
         hdr_len_ff <= hdr_len_in;
         remain_ff <= remain_in;
      end
   end

   // header parsing and payload tagging
   always_comb begin
      phase_in = phase_ff;
      len_low_in = len_low_ff;
      hdr_len_in = hdr_len_ff;
      remain_in = remain_ff;
      push_valid = 1'b0;
      push_word.payload_byte = rx_byte;
      push_word.first_of_frame = (remain_ff == hdr_len_ff);
      push_word.last_of_frame = last_byte;
      push_word.frame_length = hdr_len_ff;
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == marker) begin
                  phase_in = PH_LOW;
               end
            end
            PH_LOW: begin
               len_low_in = rx_byte;
               phase_in = PH_HIGH;
            end
            PH_HIGH: begin
               if (rx_len > max_len) begin
                  // false marker: rescan the two length bytes
                  if (len_low_ff == marker) begin
                     len_low_in = rx_byte;
                     phase_in = PH_HIGH;
                  end else if (rx_byte == marker) begin
                     phase_in = PH_LOW;
                  end else begin
                     phase_in = PH_HUNT;
                  end
               end else if (rx_len == 16'd0) begin
                  phase_in = PH_HUNT;
               end else begin
                  hdr_len_in = rx_len;
                  remain_in = rx_len;
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               push_valid = 1'b1;
               if (last_byte) begin
                  remain_in = '0;
                  phase_in = PH_HUNT;
               end else begin
                  remain_in = remain_ff - 16'd1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // a frame in progress always has bytes left within its header length
   a_remain_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (remain_ff != 16'd0 && remain_ff <= hdr_len_ff))
      else $error("payload count out of range");

   // the last payload byte returns the parser to hunting
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_DATA && last_byte) |=> (phase_ff == PH_HUNT))
      else $error("frame did not end after last byte");

   // entering payload starts with the full header length
   a_data_entry: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA && $past(phase_ff) != PH_DATA) |-> (remain_ff == hdr_len_ff))
      else $error("payload count not loaded from header");
`endif

endmodule

@@ sv/lpfd_queue.sv @@
module lpfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  lpfd_pkg::word_type push_word,
   output logic               full,
   output logic               out_valid,
   input  logic               out_ready,
   output lpfd_pkg::word_type out_word
);
   import lpfd_pkg::*;

   word_type          store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_word = store_ff[rd_ptr_ff];
   assign push = push_valid && !full;
   assign pop = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_word;
      end
   end

`ifndef SYNTHESIS
   // the fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue overfilled");

   // the parser never offers a word into a full queue
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("word pushed into full queue");

   // fill count tracks the pointer distance
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0 && count_ff != QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

@@ sv/length_prefixed_frame_deframer.sv @@
// Length-prefixed frame deframer.
// req channel: one received byte per word (req_rx_byte), valid/ready.
// rsp channel: one payload byte per word with first/last flags and the
// header's frame length, valid/ready.
// csr port: APB-style; 0x0 marker byte (reset 0x3E), 0x4 largest accepted
// payload length (reset 256). Writes complete in the access cycle; write
// only while no frame is in flight.
// The parser hunts for the marker, reads a little-endian 16-bit length and
// tags the following length bytes as payload. Header bytes, oversize and
// zero-length headers produce no output word.
// Throughput: one byte per cycle while the queue is not full.
// An accepted payload byte is registered in the queue and presented on rsp from there.
// A four-word queue sits between parser and rsp; when rsp_ready is held low
// the queue fills and req_ready drops after four payload words are pending.
// Reset (synchronous) returns the parser to hunting, empties the queue and
// restores both registers to their defaults.
module length_prefixed_frame_deframer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_payload_byte,
   output logic                              rsp_first_of_frame,
   output logic                              rsp_last_of_frame,
   output logic [15:0]                       rsp_frame_length,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lpfd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import lpfd_pkg::*;

   logic [7:0]  marker_ff;
   logic [15:0] max_len_ff;
   logic        csr_write;
   logic        queue_full;
   logic        push_valid;
   word_type    push_word;
   word_type    out_word;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MARKER_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_IDX_MARKER: marker_ff <= csr_pwdata[7:0];
            CSR_IDX_MAX_LEN: max_len_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_MARKER: csr_prdata = {24'd0, marker_ff};
         CSR_IDX_MAX_LEN: csr_prdata = {16'd0, max_len_ff};
         default: csr_prdata = '0;
      endcase
   end

   // header parser
   lpfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .rx_byte    (req_rx_byte),
      .marker     (marker_ff),
      .max_len    (max_len_ff),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_word  (push_word)
   );

   // output queue
   lpfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .full       (queue_full),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_word   (out_word)
   );

   assign rsp_payload_byte = out_word.payload_byte;
   assign rsp_first_of_frame = out_word.first_of_frame;
   assign rsp_last_of_frame = out_word.last_of_frame;
   assign rsp_frame_length = out_word.frame_length;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import lpfd_pkg::*;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] ADDR_MARKER  = {CSR_IDX_MARKER, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_LEN = {CSR_IDX_MAX_LEN, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_payload_byte;
   logic                  rsp_first_of_frame;
   logic                  rsp_last_of_frame;
   logic [15:0]           rsp_frame_length;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // deframer mirror: registers and parser state
   logic [7:0]  cfg_marker;
   logic [15:0] cfg_max_len;
   phase_type   prs_phase;
   logic [7:0]  low_len;
   logic [15:0] hdr_len;
   logic [15:0] remaining;

   word_type pending_words[$];
   int       errors;
   int       bytes_sent;
   int       send_idle_pct;
   int       stall_pct;

   length_prefixed_frame_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_first_of_frame (rsp_first_of_frame),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_frame_length   (rsp_frame_length),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // clock
   always #4 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // advance the parser mirror by one received byte
   task automatic deframe_byte(input logic [7:0] b);
      logic [15:0] len;
      word_type    w;
      len = {b, low_len};
      case (prs_phase)
         PH_HUNT: begin
            if (b == cfg_marker) prs_phase = PH_LOW;
         end
         PH_LOW: begin
            low_len = b;
            prs_phase = PH_HIGH;
         end
         PH_HIGH: begin
            if (len > cfg_max_len) begin
               // false marker: rescan the two length bytes
               if (low_len == cfg_marker) begin
                  low_len = b;
               end else if (b == cfg_marker) begin
                  prs_phase = PH_LOW;
               end else begin
                  prs_phase = PH_HUNT;
               end
            end else if (len == 16'd0) begin
               prs_phase = PH_HUNT;
            end else begin
               hdr_len = len;
               remaining = len;
               prs_phase = PH_DATA;
            end
         end
         default: begin
            w.payload_byte = b;
            w.first_of_frame = (remaining == hdr_len);
            w.last_of_frame = (remaining <= 16'd1);
            w.frame_length = hdr_len;
            pending_words.push_back(w);
            if (remaining <= 16'd1) begin
               remaining = 16'd0;
               prs_phase = PH_HUNT;
            end else begin
               remaining = remaining - 16'd1;
            end
         end
      endcase
   endtask

   // send one byte word, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'($urandom_range(255));
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deframe_byte(b);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [7:0] m, input logic [15:0] len);
      send_byte(m);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
   endtask

   // header with the current marker, then random payload
   task automatic send_payload_frame(input int len);
      send_header(cfg_marker, 16'(len));
      repeat (len) send_byte(8'($urandom_range(255)));
   endtask

   // hold the sender until every expected word is out, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_MARKER) begin
         cfg_marker = data[7:0];
      end else if (addr == ADDR_MAX_LEN) begin
         cfg_max_len = data[15:0];
      end
   endtask

   // default registers: short frames and each header corner
   task automatic test_directed_frames();
      send_idle_pct = 0;
      stall_pct = 0;
      // noise while hunting
      send_byte(8'h00);
      send_byte(8'hFF);
      // one-byte frame
      send_header(8'h3E, 16'd1);
      send_byte(8'hA5);
      // zero length is swallowed
      send_header(8'h3E, 16'd0);
      // markers inside payload are just data
      send_header(8'h3E, 16'd3);
      send_byte(8'h3E);
      send_byte(8'h3E);
      send_byte(8'hFF);
      // oversize, no marker among the length bytes
      send_header(8'h3E, 16'h0101);
      // oversize, low length byte is a marker
      send_byte(8'h3E);
      send_byte(8'h3E);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(8'h77);
      // oversize, high length byte is a marker
      send_header(8'h3E, 16'h3EFF);
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(8'hAA);
      send_byte(8'h55);
   endtask

   // register extremes: no frame allowed, then a long frame under the widest limit
   task automatic test_config_extremes();
      wait_idle();
      csr_write(ADDR_MARKER, 32'h0000_0000);
      csr_write(ADDR_MAX_LEN, 32'h0000_0000);
      send_header(8'h00, 16'd0);
      send_header(8'h00, 16'd5);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h42);
      wait_idle();
      csr_write(ADDR_MARKER, 32'h0000_00FF);
      csr_write(ADDR_MAX_LEN, 32'h0000_FFFF);
      send_byte(8'h12);
      send_payload_frame(291);
      send_payload_frame(1);
   endtask

   // random streams under each idling mix, new registers per mix
   task automatic test_random_traffic();
      int target;
      int r;
      int cap;
      int len;
      for (int p = 0; p < 4; p++) begin
         wait_idle();
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 68; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         csr_write(ADDR_MARKER, 32'($urandom_range(255)));
         case ($urandom_range(3))
            0: csr_write(ADDR_MAX_LEN, 32'd1);
            1: csr_write(ADDR_MAX_LEN, 32'($urandom_range(16, 1)));
            2: csr_write(ADDR_MAX_LEN, 32'd255);
            default: csr_write(ADDR_MAX_LEN, 32'($urandom_range(65535, 1)));
         endcase
         target = bytes_sent + 420;
         while (bytes_sent < target) begin
            r = $urandom_range(99);
            cap = (cfg_max_len > 300) ? 300 : int'(cfg_max_len);
            if ($urandom_range(9) == 0) begin
               len = $urandom_range(cap, 1);
            end else begin
               len = $urandom_range((cap > 12) ? 12 : cap, 1);
            end
            if (r < 65) begin
               send_payload_frame(len);
            end else if (r < 72) begin
               // stray marker ahead of a real header
               send_byte(cfg_marker);
               send_payload_frame(len);
            end else if (r < 78) begin
               send_header(cfg_marker, 16'd0);
            end else if (r < 88) begin
               if (cfg_max_len < 16'hFFFF) begin
                  send_header(cfg_marker, 16'($urandom_range(65535, int'(cfg_max_len) + 1)));
               end else begin
                  send_header(cfg_marker, 16'($urandom_range(65535)));
               end
            end else begin
               repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
            end
         end
      end
   endtask

   // compare each delivered word with the oldest expected one
   always @(posedge clock) begin : rsp_check
      word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word, actual byte %h first %b last %b length %h",
                     $time, rsp_payload_byte, rsp_first_of_frame, rsp_last_of_frame,
                     rsp_frame_length);
            errors++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_payload_byte !== want.payload_byte) begin
               $display("%0t: payload_byte expected %h actual %h",
                        $time, want.payload_byte, rsp_payload_byte);
               errors++;
            end
            if (rsp_first_of_frame !== want.first_of_frame) begin
               $display("%0t: first_of_frame expected %b actual %b",
                        $time, want.first_of_frame, rsp_first_of_frame);
               errors++;
            end
            if (rsp_last_of_frame !== want.last_of_frame) begin
               $display("%0t: last_of_frame expected %b actual %b",
                        $time, want.last_of_frame, rsp_last_of_frame);
               errors++;
            end
            if (rsp_frame_length !== want.frame_length) begin
               $display("%0t: frame_length expected %h actual %h",
                        $time, want.frame_length, rsp_frame_length);
               errors++;
            end
         end
      end
   end

   // main sequence
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = 32'h0;
      errors = 0;
      bytes_sent = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      cfg_marker = MARKER_RESET;
      cfg_max_len = MAX_LEN_RESET;
      prs_phase = PH_HUNT;
      low_len = 8'h00;
      hdr_len = 16'h0;
      remaining = 16'h0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_config_extremes();
      test_random_traffic();
      stall_pct = 0;
      wait_idle();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/lpfd_pkg.sv
sv/lpfd_front.sv
sv/lpfd_queue.sv
sv/length_prefixed_frame_deframer.sv
tb/tb_top.sv
